/* src/rgbhsl_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared types and constants of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int HUE_W = 15;
	localparam int FRAC_W = 16;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] lightness;
	} hsl_t;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

endpackage

/* src/rgb_to_hsl_converter.sv */
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Pipelined pixel conversion: front end, two bit-serial divider pipelines,
// hue wrap, lightness by reciprocal multiply and output register.
// ----------------------------------------------------------------------------
//  channel | signals                     | transfer
//  input   | start, busy, pixel          | start high and busy low
//  output  | done, hsl                   | done high, one cycle, no stall
//
//  One pixel per cycle. Two front-end stages, then the dividers at one quotient
//  bit per stage (more stages when the hue needs more than 17 quotient bits),
//  then the output stage. Lightness rides along with the saturation divider.
//  busy stays low; the output cannot be held, so nothing ever stalls.
//  Reset clears the valid bits only.
module rgb_to_hsl_converter #(
	parameter int CHANNEL_BITS  = rgbhsl_pkg::CHANNEL_BITS_DEF,
	parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rgbhsl_pkg::pixel_t pixel,
	output logic               done,
	output rgbhsl_pkg::hsl_t   hsl
);

	localparam int CB   = CHANNEL_BITS;
	localparam int HN_W = CB + HUE_FRAC_BITS + 12;
	localparam int HQ_W = HUE_FRAC_BITS + 10;
	localparam logic [HQ_W-1:0] HUE_FULL = HQ_W'(360 << HUE_FRAC_BITS);
	localparam int DQ   = (HQ_W > 17) ? HQ_W : 17;

	// lightness = floor((sum*LIG_MUL + 2^(LIG_K-1)) >> LIG_K), exact for every sum
	localparam int LIG_K = 2 * CB + 3;
	localparam int LM_W  = CB + 19;
	localparam int P_W   = 2 * CB + 20;
	localparam longint LIG_D = 2 * ((longint'(1) << CB) - 1);
	localparam longint LIG_N = (longint'(1) << LIG_K) * 65535;
	localparam logic [LM_W-1:0] LIG_MUL  = LM_W'((LIG_N + LIG_D - 1) / LIG_D);
	localparam logic [P_W-1:0]  LIG_HALF = P_W'(longint'(1) << (LIG_K - 1));

	logic              p_valid, p_grey;
	logic [CB:0]       lig_sum;
	logic [CB+16:0]    sat_num;
	logic [CB+1:0]     sat_den;
	logic [HN_W-1:0]   hue_num;
	logic [CB-1:0]     hue_den;

	assign busy = 1'b0;

	rgbhsl_prep #(.CHANNEL_BITS(CB), .HUE_FRAC_BITS(HUE_FRAC_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .pixel(pixel),
		.out_valid(p_valid), .grey(p_grey), .lig_sum(lig_sum),
		.sat_num(sat_num), .sat_den(sat_den), .hue_num(hue_num), .hue_den(hue_den)
	);

	logic            s_v, h_v, g_d;
	logic [DQ-1:0]   s_q;
	logic [DQ-1:0]   h_q;
	logic [CB+1:0]   t_s;

	rgbhsl_div #(.NUM_W(CB+17), .DEN_W(CB+1), .Q_W(DQ), .TAG_W(CB+2)) u_sat (
		.clk(clk), .arst_n(arst_n), .in_valid(p_valid), .num(sat_num),
		.den(sat_den[CB:0]), .tag_in({p_grey, lig_sum}), .out_valid(s_v), .quo(s_q),
		.tag_out(t_s)
	);

	rgbhsl_div #(.NUM_W(HN_W), .DEN_W(CB), .Q_W(DQ), .TAG_W(1)) u_hue (
		.clk(clk), .arst_n(arst_n), .in_valid(p_valid), .num(hue_num),
		.den(hue_den), .tag_in(p_grey), .out_valid(h_v), .quo(h_q), .tag_out(g_d)
	);

	logic [HQ_W-1:0] hq;
	always_comb begin
		hq = h_q[HQ_W-1:0];
		if (hq >= HUE_FULL) hq = hq - HUE_FULL;
	end

	logic [P_W-1:0] lig_prod;
	always_comb begin
		lig_prod = P_W'(t_s[CB:0]) * P_W'(LIG_MUL) + LIG_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= h_v & s_v;
		end
	end

	// grey pixels drop hue and saturation to zero
	always_ff @(posedge clk) begin
		hsl.hue        <= g_d ? '0 : rgbhsl_pkg::HUE_W'(hq);
		hsl.saturation <= t_s[CB+1] ? '0 : s_q[15:0];
		hsl.lightness  <= lig_prod[LIG_K+15:LIG_K];
	end

endmodule

/* src/rgbhsl_div.sv */
// ----------------------------------------------------------------------------
// RGB to HSL pipelined divider
// Rounded unsigned division, one quotient bit per stage, one item per cycle.
// Gives round(num/den) as floor((2*num + den) / (2*den)).
// ----------------------------------------------------------------------------
module rgbhsl_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int Q_W   = 16,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);

	localparam int N_W = NUM_W + 2;
	localparam int D_W = DEN_W + 1;
	localparam int R_W = D_W + 1;

	logic             v_q   [0:Q_W];
	logic [N_W-1:0]   n_q   [0:Q_W];
	logic [D_W-1:0]   d_q   [0:Q_W];
	logic [R_W-1:0]   r_q   [0:Q_W];
	logic [Q_W-1:0]   q_q   [0:Q_W];
	logic [TAG_W-1:0] t_q   [0:Q_W];

	always_comb begin
		v_q[0] = in_valid;
		n_q[0] = ({2'b0, num} << 1) + {{(N_W-DEN_W){1'b0}}, den};
		d_q[0] = {den, 1'b0};
		r_q[0] = '0;
		q_q[0] = '0;
		t_q[0] = tag_in;
	end

	// restoring division, low Q_W quotient bits; higher bits are known zero
	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [R_W-1:0] trial;
		logic [R_W-1:0] diff;
		logic           bitin;
		always_comb begin
			if (N_W - Q_W + i >= 0)
				bitin = n_q[i][Q_W-1-i];
			else
				bitin = 1'b0;
		end
		// remainder carries the top numerator bits on entry
		always_comb begin
			if (i == 0)
				trial = R_W'(n_q[0] >> Q_W);
			else
				trial = {r_q[i][R_W-2:0], bitin};
			if (i == 0)
				trial = {trial[R_W-2:0], bitin};
			diff = trial - {1'b0, d_q[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			n_q[i+1] <= n_q[i];
			d_q[i+1] <= d_q[i];
			t_q[i+1] <= t_q[i];
			if (trial >= {1'b0, d_q[i]}) begin
				r_q[i+1] <= diff;
				q_q[i+1] <= {q_q[i][Q_W-2:0], 1'b1};
			end else begin
				r_q[i+1] <= trial;
				q_q[i+1] <= {q_q[i][Q_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_q[Q_W];
	assign quo       = q_q[Q_W];
	assign tag_out   = t_q[Q_W];

endmodule

/* src/rgbhsl_prep.sv */
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Two registered stages: max, min and sector, then dividends and divisors.
// ----------------------------------------------------------------------------
module rgbhsl_prep #(
	parameter int CHANNEL_BITS  = rgbhsl_pkg::CHANNEL_BITS_DEF,
	parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rgbhsl_pkg::pixel_t   pixel,
	output logic                 out_valid,
	output logic                 grey,
	output logic [CHANNEL_BITS:0]    lig_sum,
	output logic [CHANNEL_BITS+16:0] sat_num,
	output logic [CHANNEL_BITS+1:0]  sat_den,
	output logic [CHANNEL_BITS+HUE_FRAC_BITS+11:0] hue_num,
	output logic [CHANNEL_BITS-1:0]  hue_den
);

	localparam int CB = CHANNEL_BITS;
	localparam int PB = 8;
	localparam int HN_W = CB + HUE_FRAC_BITS + 12;
	localparam logic [CB:0] FS = (CB+1)'((1 << CB) - 1);

	logic [CB-1:0] r, g, b;
	logic [CB-1:0] mx, mn;
	rgbhsl_pkg::sector_t sect;

	always_comb begin
		r = CB'({{(CB > PB ? CB-PB : 1){1'b0}}, pixel.red});
		g = CB'({{(CB > PB ? CB-PB : 1){1'b0}}, pixel.green});
		b = CB'({{(CB > PB ? CB-PB : 1){1'b0}}, pixel.blue});
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		if (mx == r)      sect = rgbhsl_pkg::SECT_RED;
		else if (mx == g) sect = rgbhsl_pkg::SECT_GREEN;
		else              sect = rgbhsl_pkg::SECT_BLUE;
	end

	logic                v_s1;
	logic [CB-1:0]       r_s1, g_s1, b_s1, mx_s1, mn_s1;
	rgbhsl_pkg::sector_t sect_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r; g_s1 <= g; b_s1 <= b;
		mx_s1 <= mx; mn_s1 <= mn; sect_s1 <= sect;
	end

	logic [CB:0]   sum, den;
	logic [CB-1:0] delta;
	logic [CB+3:0] num;

	always_comb begin
		sum   = {1'b0, mx_s1} + {1'b0, mn_s1};
		delta = mx_s1 - mn_s1;
		den   = (sum < FS) ? sum : ((FS << 1) - sum);
		case (sect_s1)
			rgbhsl_pkg::SECT_RED: begin
				if (g_s1 >= b_s1)
					num = (CB+4)'(g_s1) - (CB+4)'(b_s1);
				else
					num = (CB+4)'(6 * (CB+4)'(delta)
						- ((CB+4)'(b_s1) - (CB+4)'(g_s1)));
			end
			rgbhsl_pkg::SECT_GREEN:
				num = (CB+4)'(2 * (CB+4)'(delta) + (CB+4)'(b_s1) - (CB+4)'(r_s1));
			default:
				num = (CB+4)'(4 * (CB+4)'(delta) + (CB+4)'(r_s1) - (CB+4)'(g_s1));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end

	// x*65535 = (x<<16) - x; hue unit is 60 shifted, i.e. (x<<6)-(x<<2)
	always_ff @(posedge clk) begin
		grey    <= (delta == '0);
		lig_sum <= sum;
		sat_num <= ((CB+17)'(delta) << 16) - (CB+17)'(delta);
		sat_den <= (CB+2)'(den);
		hue_num <= (((HN_W)'(num) << 6) - ((HN_W)'(num) << 2)) << HUE_FRAC_BITS;
		hue_den <= delta;
	end

endmodule

/* tb/tb_rgb_to_hsl_converter.sv */
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives pixels through the command interface, predicts hue, saturation and
// lightness in exact integer arithmetic and checks every result in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter;
	typedef rgbhsl_pkg::pixel_t pixel_t;
	typedef rgbhsl_pkg::hsl_t   hsl_t;

	localparam int FS         = 255;
	localparam int HUE_UNIT   = 60 * 64;
	localparam int N_RANDOM   = 1930;
	localparam int LATENCY    = 20;
	localparam int CYCLE_MAX  = 200000;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsl_t   hsl;

	hsl_t   hsl_pending[$];
	int     n_fail;
	int     cycles;

	typedef struct {
		pixel_t px;
		bit     known;
		hsl_t   res;
	} vec_t;

	rgb_to_hsl_converter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .done(done), .hsl(hsl)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint div_nearest(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic hsl_t convert_pixel(pixel_t px);
		hsl_t   o;
		longint r, g, b, hi, lo, d, s, den, num, h;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = (r > g) ? r : g;
		hi = (b > hi) ? b : hi;
		lo = (r < g) ? r : g;
		lo = (b < lo) ? b : lo;
		d = hi - lo;
		s = hi + lo;
		o.lightness = 16'(div_nearest(s * 65535, 2 * FS));
		o.hue = '0;
		o.saturation = '0;
		if (d != 0) begin
			den = (s < FS) ? s : (2 * FS - s);
			o.saturation = 16'(div_nearest(d * 65535, den));
			if (hi == r)
				num = (g >= b) ? g - b : 6 * d - (b - g);
			else if (hi == g)
				num = 2 * d + b - r;
			else
				num = 4 * d + r - g;
			h = div_nearest(num * HUE_UNIT, d);
			if (h >= 6 * HUE_UNIT)
				h -= 6 * HUE_UNIT;
			o.hue = 15'(h);
		end
		return o;
	endfunction

	// expected result is tracked for every transfer; the typed rows are checked too
	task automatic send_pixel(pixel_t px, bit known, hsl_t res);
		hsl_t exp_res;
		exp_res = convert_pixel(px);
		if (known && exp_res != res) begin
			$error("table row %h: hue exp %0d, saturation exp %0d, lightness exp %0d",
				px, res.hue, res.saturation, res.lightness);
			n_fail++;
		end
		pixel <= px;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		hsl_pending.push_back(known ? res : exp_res);
		@(negedge clk);
	endtask

	task automatic gap_burst(bit allow);
		int n;
		if (allow && $urandom_range(3) == 0) begin
			n = $urandom_range(18, 1);
			start <= 1'b0;
			pixel <= pixel_t'($urandom);
			repeat (n) @(negedge clk);
		end
	endtask

	// check every result strobe against the oldest expectation
	always @(posedge clk) begin
		hsl_t want;
		if (arst_n && done) begin
			if (hsl_pending.size() == 0) begin
				$error("result with no pixel outstanding: %h", hsl);
				n_fail++;
			end else begin
				want = hsl_pending.pop_front();
				if (hsl.hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hsl.hue);
					n_fail++;
				end
				if (hsl.saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d",
						want.saturation, hsl.saturation);
					n_fail++;
				end
				if (hsl.lightness !== want.lightness) begin
					$error("lightness: expected %0d, got %0d",
						want.lightness, hsl.lightness);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("tb_rgb_to_hsl_converter: FAIL");
			$finish;
		end
	end

	initial begin
		vec_t   rows[$];
		pixel_t px;
		int     k, lim;
		n_fail = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		// extremes typed in; hue is in 1/64 degree
		rows.push_back('{pixel_t'{8'd0,   8'd0,   8'd0},   1, hsl_t'{15'd0,     16'd0,     16'd0}});
		rows.push_back('{pixel_t'{8'd255, 8'd255, 8'd255}, 1, hsl_t'{15'd0,     16'd0,     16'd65535}});
		rows.push_back('{pixel_t'{8'd255, 8'd0,   8'd0},   1, hsl_t'{15'd0,     16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd0,   8'd255, 8'd0},   1, hsl_t'{15'd7680,  16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd0,   8'd0,   8'd255}, 1, hsl_t'{15'd15360, 16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd255, 8'd255, 8'd0},   1, hsl_t'{15'd3840,  16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd0,   8'd255, 8'd255}, 1, hsl_t'{15'd11520, 16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd255, 8'd0,   8'd255}, 1, hsl_t'{15'd19200, 16'd65535, 16'd32768}});
		rows.push_back('{pixel_t'{8'd128, 8'd128, 8'd128}, 0, hsl_t'('0)});
		// hue just under a full turn, which may round up to zero
		rows.push_back('{pixel_t'{8'd255, 8'd0,   8'd1},   0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd255, 8'd0,   8'd254}, 0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd1,   8'd0,   8'd0},   0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd254, 8'd255, 8'd255}, 0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd200, 8'd100, 8'd100}, 0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd127, 8'd128, 8'd0},   0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd128, 8'd127, 8'd0},   0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd10,  8'd20,  8'd30},  0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd30,  8'd20,  8'd30},  0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd170, 8'd85,  8'd170}, 0, hsl_t'('0)});
		rows.push_back('{pixel_t'{8'd85,  8'd170, 8'd170}, 0, hsl_t'('0)});
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			send_pixel(rows[i].px, rows[i].known, rows[i].res);
			gap_burst(1'b1);
		end
		for (k = 0; k < N_RANDOM; k++) begin
			px = pixel_t'($urandom);
			case ($urandom_range(5))
				0: px.green = px.red;
				1: begin px.green = px.red; px.blue = px.red; end
				2: px.blue = (px.red > px.green) ? px.red : px.green;
				3: begin
					px.red = 8'($urandom_range(255, 250));
					px.green = 8'($urandom_range(5));
				end
				default: ;
			endcase
			send_pixel(px, 1'b0, hsl_t'('0));
			gap_burst(k < N_RANDOM - 300);
		end
		start <= 1'b0;
		lim = 0;
		while (hsl_pending.size() != 0 && lim < 10000) begin
			@(posedge clk);
			lim++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (n_fail == 0 && hsl_pending.size() == 0)
			$display("tb_rgb_to_hsl_converter: PASS");
		else
			$display("tb_rgb_to_hsl_converter: FAIL");
		$finish;
	end

endmodule
